/* src/srtf_pkg.sv */
`timescale 1ns / 1ps
// Package for the SRTF tick scheduler: request/result structs, status and
// opcode codes, sequencer states. No dependencies.
package srtf_pkg;

    localparam int MAX_JOBS_DEF = 16;

    localparam logic [15:0] TICK_MAX = 16'hFFFF;

    // Opcodes of a request
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RAN    = 3'd1;
    localparam logic [2:0] ST_DONE   = 3'd2;
    localparam logic [2:0] ST_ADDED  = 3'd3;
    localparam logic [2:0] ST_REJECT = 3'd4;

    typedef struct packed {
        logic        opcode;
        logic [15:0] arrival_time;
        logic [11:0] burst_time;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  job_slot;
        logic [15:0] completion_time;
        logic [15:0] waiting_time;
        logic [15:0] turnaround_time;
    } t_res;

    // One job table entry
    typedef struct packed {
        logic [15:0] arrival;
        logic [11:0] burst;
        logic [11:0] remaining;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT
    } t_state;

endpackage

/* src/srtf_job_mem.sv */
`timescale 1ns / 1ps
// Job table memory: one write port, one registered read port.
// Depends on srtf_pkg (t_entry).
module srtf_job_mem
    import srtf_pkg::*;
#(
    parameter int DEPTH = MAX_JOBS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/srtf_scan.sv */
`timescale 1ns / 1ps
// Shared compare unit: folds one table entry per cycle into the running best
// candidate (least remaining, then earlier arrival, then lower slot).
// Depends on srtf_pkg (t_entry).
module srtf_scan
    import srtf_pkg::*;
#(
    parameter int AW = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    input  logic          i_take,
    input  t_entry        i_entry,
    input  logic [AW-1:0] i_slot,
    input  logic [15:0]   i_tick,
    output logic          o_found,
    output t_entry        o_best,
    output logic [AW-1:0] o_best_slot
);

    logic          r_found;
    t_entry        r_best;
    logic [AW-1:0] r_best_slot;
    logic          eligible;
    logic          better;

    // eligibility and ordering; strict compares keep the lower slot on ties
    always_comb begin
        eligible = (i_entry.arrival <= i_tick) && (i_entry.remaining != 12'd0);
        better   = !r_found
                 || (i_entry.remaining < r_best.remaining)
                 || ((i_entry.remaining == r_best.remaining)
                     && (i_entry.arrival < r_best.arrival));
    end

    // found flag is control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_clear) begin
            r_found <= 1'b0;
        end else if (i_take && eligible) begin
            r_found <= 1'b1;
        end
    end

    // best candidate payload
    always_ff @(posedge i_clk) begin
        if (i_take && eligible && better) begin
            r_best      <= i_entry;
            r_best_slot <= i_slot;
        end
    end

    assign o_found     = r_found;
    assign o_best      = r_best;
    assign o_best_slot = r_best_slot;

endmodule

/* src/srtf_tick_scheduler_top.sv */
`timescale 1ns / 1ps
// Top level of the SRTF tick scheduler: sequencer, job count, tick counter,
// output register. Depends on srtf_pkg, srtf_job_mem, srtf_scan.
//
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+--------------------
//  request  | i_req_valid  | o_req_ready  | i_req  (t_req)
//  result   | o_res_valid  | i_res_ready  | o_res  (t_res)
//
// An add goes from acceptance through the result step to the output register. A tick
// scans every stored job: the shared compare unit reads one slot per cycle
// through the table's single registered read port.
// Reset is synchronous, active low; it clears the sequencer state, job count, tick counter and result valid.
// A new request is taken while a previous result still waits in the output
// register; a stalled result holds the sequencer in its result step.
module srtf_tick_scheduler_top
    import srtf_pkg::*;
#(
    parameter int MAX_JOBS = MAX_JOBS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_res_valid,
    input  logic i_res_ready,
    output t_res o_res
);

    localparam int AW = $clog2(MAX_JOBS);
    localparam int CW = $clog2(MAX_JOBS + 1);

    t_state        r_state, n_state;
    t_req          r_req;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_rd_vld, n_rd_vld;
    logic [CW-1:0] r_count, n_count;
    logic [15:0]   r_tick, n_tick;
    logic          r_res_valid, n_res_valid;
    t_res          r_res, n_res;

    logic          req_acc;
    logic          out_free;
    logic          issue;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    t_entry        mem_rdata;
    logic [AW-1:0] rd_slot;
    logic          scan_found;
    t_entry        scan_best;
    logic [AW-1:0] scan_slot;
    logic [11:0]   rem_next;
    logic [15:0]   tick_next;
    logic [15:0]   turn;
    logic          add_ok;

    assign req_acc  = i_req_valid && o_req_ready;
    assign out_free = !r_res_valid || i_res_ready;
    assign issue    = (r_state == S_SCAN) && (r_idx < r_count);

    srtf_job_mem #(
        .DEPTH (MAX_JOBS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (issue),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    srtf_scan #(
        .AW (AW)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (req_acc),
        .i_take      (r_rd_vld),
        .i_entry     (mem_rdata),
        .i_slot      (rd_slot),
        .i_tick      (r_tick),
        .o_found     (scan_found),
        .o_best      (scan_best),
        .o_best_slot (scan_slot)
    );

    // slot of the entry now on the read data bus
    logic [AW-1:0] r_rd_slot;
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_slot <= r_idx[AW-1:0];
        end
    end
    assign rd_slot = r_rd_slot;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_state = (i_req.opcode == OP_TICK) ? S_SCAN : S_RESULT;
                end
            end
            S_SCAN: begin
                if (!issue && !r_rd_vld) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result arithmetic on the chosen job
    always_comb begin
        rem_next  = scan_best.remaining - 12'd1;
        tick_next = (r_tick == TICK_MAX) ? r_tick : r_tick + 16'd1;
        turn      = tick_next - scan_best.arrival;
        add_ok    = (r_req.burst_time != 12'd0) && (r_count != CW'(MAX_JOBS));
    end

    // sequencer outputs and datapath updates
    always_comb begin
        o_req_ready = (r_state == S_IDLE);
        n_idx       = r_idx;
        n_rd_vld    = issue;
        n_count     = r_count;
        n_tick      = r_tick;
        n_res_valid = r_res_valid && !i_res_ready;
        n_res       = r_res;
        mem_we      = 1'b0;
        mem_waddr   = scan_slot;
        mem_wdata   = '{arrival: scan_best.arrival, burst: scan_best.burst,
                        remaining: rem_next};
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
            end
            S_SCAN: begin
                if (issue) begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_res_valid = 1'b1;
                    n_res       = '0;
                    if (r_req.opcode == OP_ADD) begin
                        if (add_ok) begin
                            mem_we          = 1'b1;
                            mem_waddr       = r_count[AW-1:0];
                            mem_wdata       = '{arrival: r_req.arrival_time,
                                                burst: r_req.burst_time,
                                                remaining: r_req.burst_time};
                            n_count         = r_count + CW'(1);
                            n_res.status    = ST_ADDED;
                            n_res.job_slot  = 4'(r_count);
                        end else begin
                            n_res.status    = ST_REJECT;
                        end
                    end else begin
                        n_tick = tick_next;
                        if (scan_found) begin
                            mem_we         = 1'b1;
                            n_res.job_slot = 4'(scan_slot);
                            if (rem_next == 12'd0) begin
                                n_res.status          = ST_DONE;
                                n_res.completion_time = tick_next;
                                n_res.turnaround_time = turn;
                                n_res.waiting_time    =
                                    (turn >= 16'(scan_best.burst))
                                    ? turn - 16'(scan_best.burst) : 16'd0;
                            end else begin
                                n_res.status = ST_RAN;
                            end
                        end else begin
                            n_res.status = ST_IDLE;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_count     <= '0;
            r_tick      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_rd_vld    <= n_rd_vld;
            r_count     <= n_count;
            r_tick      <= n_tick;
            r_res_valid <= n_res_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_req <= i_req;
        end
        r_res <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

/* src/srtf_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the SRTF tick scheduler, bound to the top level.
// Depends on srtf_pkg and srtf_tick_scheduler_top.
module srtf_checker
    import srtf_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic o_req_ready,
    input t_req i_req,
    input logic o_res_valid,
    input logic i_res_ready,
    input t_res o_res
);

    // a result waiting for the consumer holds its payload
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res))
        else $error("result changed while stalled");

    // one request at a time: ready drops after an accepted request
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request accepted while busy");

    // only defined status codes appear
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.status == ST_IDLE || o_res.status == ST_RAN ||
                         o_res.status == ST_DONE || o_res.status == ST_ADDED ||
                         o_res.status == ST_REJECT))
        else $error("bad status code");

    // timing fields are zero unless a job finished; waiting never exceeds turnaround
    a_times: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> ((o_res.status == ST_DONE)
                         ? (o_res.waiting_time <= o_res.turnaround_time)
                         : (o_res.completion_time == 16'd0 &&
                            o_res.waiting_time == 16'd0 &&
                            o_res.turnaround_time == 16'd0)))
        else $error("inconsistent timing fields");

endmodule

bind srtf_tick_scheduler_top srtf_checker u_srtf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .i_req       (i_req),
    .o_res_valid (o_res_valid),
    .i_res_ready (i_res_ready),
    .o_res       (o_res)
);
